### hdl/jdvm_pkg.sv
// Package: widths, codes, state types and control structs for the joystick velocity mapper.
package jdvm_pkg;

	localparam int KIND_W    = 8;
	localparam int IDX_W     = 8;
	localparam int LVL_W     = 16;
	localparam int VEL_W     = 16;
	localparam int CFG_W     = 15;
	localparam int REG_IDX_W = 3;
	localparam int MAG_W     = 15;
	localparam int PROD_W    = 2 * MAG_W;
	localparam int MUL_W     = MAG_W + 1;
	localparam int MUL_STEPS = MUL_W / 2;
	localparam int DIV_STEPS = MAG_W;
	localparam int CNT_W     = 4;

	localparam logic [KIND_W-2:0] KIND_BUTTON = 7'd1;
	localparam logic [KIND_W-2:0] KIND_AXIS   = 7'd2;

	localparam logic [CFG_W-1:0] DZ_MOVE_RST  = 15'd4000;
	localparam logic [CFG_W-1:0] DZ_TURN_RST  = 15'd8000;
	localparam logic [CFG_W-1:0] MAX_X_RST    = 15'd7680;
	localparam logic [CFG_W-1:0] MAX_Y_RST    = 15'd6400;
	localparam logic [CFG_W-1:0] MAX_TURN_RST = 15'd5120;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_DZ_MOVE  = 3'd0,
		REG_DZ_TURN  = 3'd1,
		REG_MAX_X    = 3'd2,
		REG_MAX_Y    = 3'd3,
		REG_MAX_TURN = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		TGT_NONE,
		TGT_X,
		TGT_Y,
		TGT_TURN
	} tgt_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_CALC,
		ST_WRITE
	} ctl_state_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV,
		MD_DONE
	} md_state_t;

	typedef struct packed {
		logic             start;
		logic [MAG_W-1:0] a;
		logic [MAG_W-1:0] b;
		logic [MAG_W-1:0] dvs;
	} md_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [MAG_W-1:0] quo;
	} md_rsp_t;

endpackage

### hdl/jdvm_evt_if.sv
// Interface: joystick event channel.
interface jdvm_evt_if import jdvm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] event_kind;
	logic [IDX_W-1:0]  event_index;
	logic signed [LVL_W-1:0] event_level;

	modport source(output valid, output event_kind, output event_index, output event_level,
		input ready);
	modport sink(input valid, input event_kind, input event_index, input event_level,
		output ready);
endinterface

### hdl/jdvm_res_if.sv
// Interface: velocity result channel.
interface jdvm_res_if import jdvm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VEL_W-1:0] vel_x;
	logic signed [VEL_W-1:0] vel_y;
	logic signed [VEL_W-1:0] vel_turn;
	logic                    enabled;

	modport source(output valid, output vel_x, output vel_y, output vel_turn, output enabled,
		input ready);
	modport sink(input valid, input vel_x, input vel_y, input vel_turn, input enabled,
		output ready);
endinterface

### hdl/jdvm_cfg_if.sv
// Interface: configuration register write channel.
interface jdvm_cfg_if import jdvm_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] reg_index;
	logic [CFG_W-1:0]     wdata;

	modport source(output valid, output reg_index, output wdata, input ready);
	modport sink(input valid, input reg_index, input wdata, output ready);
endinterface

### hdl/joystick_deadzone_velocity_mapper.sv
// Top level: joystick event decode, deadzone rescale through a serial unit, held velocity outputs.
//
//  channel | dir | handshake    | payload
//  evt     | in  | valid/ready  | event_kind[8], event_index[8], event_level[16] signed
//  res     | out | valid/ready  | vel_x, vel_y, vel_turn [16] signed Q8, enabled
//  cfg     | in  | valid/ready  | reg_index[3], wdata[15]
//
// An axis event that leaves the deadzone is rescaled by 8 radix-4 multiply steps and
// 15 restoring divide steps in jdvm_muldiv. One event is in work at a time.
// The next event is taken while the previous result waits on res.ready.
// arst_n clears held velocities and the active flag and restores the register defaults.
module joystick_deadzone_velocity_mapper import jdvm_pkg::*; #(
	parameter int unsigned AXIS_FULL_SCALE = 32767
) (
	input logic       clk,
	input logic       arst_n,
	jdvm_evt_if.sink  evt,
	jdvm_res_if.source res,
	jdvm_cfg_if.sink  cfg
);

	localparam logic [MAG_W-1:0] FULL_SCALE = MAG_W'(AXIS_FULL_SCALE);

	logic [CFG_W-1:0] dz_move_q, dz_turn_q, max_x_q, max_y_q, max_turn_q;

	ctl_state_t state_q, state_d;
	logic [KIND_W-2:0] kind_q;
	logic [IDX_W-1:0]  idx_q;
	logic [LVL_W-1:0]  lvl_q;
	tgt_t              tgt_q, tgt;
	logic              neg_q, toggle_q;
	logic [MAG_W-1:0]  val_q;

	logic signed [VEL_W-1:0] held_x_q, held_y_q, held_turn_q, new_val;
	logic                    enable_q, res_valid_q;

	logic [LVL_W-1:0] mag;
	logic [MAG_W-1:0] m, dz_sel, max_sel;
	logic             live, toggle, evt_take, out_free, load_out;
	md_req_t          md_req;
	md_rsp_t          md_rsp;

	assign cfg.ready = 1'b1;
	assign evt_take  = evt.valid && evt.ready;
	assign out_free  = !res_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_move_q  <= DZ_MOVE_RST;
			dz_turn_q  <= DZ_TURN_RST;
			max_x_q    <= MAX_X_RST;
			max_y_q    <= MAX_Y_RST;
			max_turn_q <= MAX_TURN_RST;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.reg_index))
				REG_DZ_MOVE:  dz_move_q  <= cfg.wdata;
				REG_DZ_TURN:  dz_turn_q  <= cfg.wdata;
				REG_MAX_X:    max_x_q    <= cfg.wdata;
				REG_MAX_Y:    max_y_q    <= cfg.wdata;
				REG_MAX_TURN: max_turn_q <= cfg.wdata;
				default: ;
			endcase
		end
	end

	// decode and deadzone test on the latched event
	always_comb begin
		tgt = TGT_NONE;
		if (kind_q == KIND_AXIS) begin
			if (idx_q == 8'd0)
				tgt = TGT_Y;
			else if (idx_q == 8'd1)
				tgt = TGT_X;
			else if (idx_q inside {8'd2, 8'd3})
				tgt = TGT_TURN;
		end
		toggle  = (kind_q == KIND_BUTTON) && (idx_q == 8'd0) && (lvl_q == 16'd1);
		dz_sel  = (tgt == TGT_TURN) ? dz_turn_q : dz_move_q;
		case (tgt)
			TGT_X:    max_sel = max_x_q;
			TGT_Y:    max_sel = max_y_q;
			TGT_TURN: max_sel = max_turn_q;
			default:  max_sel = '0;
		endcase
		mag  = lvl_q[LVL_W-1] ? (~lvl_q + 1'b1) : lvl_q;
		m    = (mag > {1'b0, FULL_SCALE}) ? FULL_SCALE : mag[MAG_W-1:0];
		live = (m > dz_sel);
	end

	always_comb begin
		md_req.start = (state_q == ST_PREP) && (tgt != TGT_NONE) && live;
		md_req.a     = m - dz_sel;
		md_req.b     = max_sel;
		md_req.dvs   = FULL_SCALE - dz_sel;
	end

	jdvm_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (evt_take) state_d = ST_PREP;
			ST_PREP:  state_d = md_req.start ? ST_CALC : ST_WRITE;
			ST_CALC:  if (md_rsp.done) state_d = ST_WRITE;
			ST_WRITE: if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		evt.ready = (state_q == ST_IDLE);
		load_out  = (state_q == ST_WRITE) && out_free;
		new_val   = neg_q ? -$signed({1'b0, val_q}) : $signed({1'b0, val_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (evt_take) begin
			kind_q <= evt.event_kind[KIND_W-2:0];
			idx_q  <= evt.event_index;
			lvl_q  <= evt.event_level;
		end
		if (state_q == ST_PREP) begin
			tgt_q    <= tgt;
			neg_q    <= lvl_q[LVL_W-1];
			toggle_q <= toggle;
			val_q    <= '0;
		end else if (state_q == ST_CALC && md_rsp.done) begin
			val_q <= md_rsp.quo;
		end
	end

	// held commands double as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_x_q    <= '0;
			held_y_q    <= '0;
			held_turn_q <= '0;
			enable_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				case (tgt_q)
					TGT_X:    held_x_q    <= new_val;
					TGT_Y:    held_y_q    <= new_val;
					TGT_TURN: held_turn_q <= new_val;
					default: ;
				endcase
				enable_q    <= enable_q ^ toggle_q;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid    = res_valid_q;
	assign res.vel_x    = held_x_q;
	assign res.vel_y    = held_y_q;
	assign res.vel_turn = held_turn_q;
	assign res.enabled  = enable_q;

	a_start_in_prep: assert property (@(posedge clk) disable iff (!arst_n)
		md_req.start |-> state_q == ST_PREP)
		else $error("arith start outside prep");

	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		md_rsp.done |-> state_q == ST_CALC)
		else $error("arith done while not waiting");

	a_calc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC) |-> md_rsp.busy)
		else $error("waiting on idle arith unit");

	a_take_to_prep: assert property (@(posedge clk) disable iff (!arst_n)
		evt_take |=> state_q == ST_PREP)
		else $error("event transaction not decoded");

	a_no_min_vel: assert property (@(posedge clk) disable iff (!arst_n)
		held_x_q != 16'sh8000 && held_y_q != 16'sh8000 && held_turn_q != 16'sh8000)
		else $error("velocity out of range");

endmodule

### hdl/jdvm_muldiv.sv
// Serial multiply-then-divide unit: radix-4 shift-add product, restoring bit-serial quotient.
module jdvm_muldiv import jdvm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  md_req_t req,
	output md_rsp_t rsp
);

	md_state_t state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [MAG_W-1:0]  a_q;
	logic [MAG_W-1:0]  dvs_q;
	logic [MUL_W-1:0]  bsh_q;
	logic [PROD_W-1:0] sh_q;

	logic [PROD_W-1:0] pp_hi, pp_lo, mul_nxt;
	logic [MAG_W:0]    trial, rem_nxt;
	logic              q_bit;
	logic              last_mul, last_div;

	assign last_mul = (cnt_q == CNT_W'(MUL_STEPS - 1));
	assign last_div = (cnt_q == CNT_W'(DIV_STEPS - 1));

	always_comb begin
		pp_hi   = bsh_q[MUL_W-1] ? {(PROD_W-MAG_W-1)'(0), a_q, 1'b0} : '0;
		pp_lo   = bsh_q[MUL_W-2] ? {(PROD_W-MAG_W)'(0), a_q} : '0;
		mul_nxt = {sh_q[PROD_W-3:0], 2'b00} + pp_hi + pp_lo;
		trial   = {sh_q[PROD_W-1:MAG_W], sh_q[MAG_W-1]};
		q_bit   = (trial >= {1'b0, dvs_q});
		rem_nxt = q_bit ? (trial - {1'b0, dvs_q}) : trial;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			MD_IDLE:  if (req.start) state_d = MD_MUL;
			MD_MUL:   if (last_mul) state_d = MD_DIV;
			MD_DIV:   if (last_div) state_d = MD_DONE;
			MD_DONE:  state_d = MD_IDLE;
			default:  state_d = MD_IDLE;
		endcase
	end

	always_comb begin
		rsp.busy = (state_q != MD_IDLE);
		rsp.done = (state_q == MD_DONE);
		rsp.quo  = sh_q[MAG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == MD_IDLE || (state_q == MD_MUL && last_mul))
				cnt_q <= '0;
			else
				cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MD_IDLE: begin
				if (req.start) begin
					a_q   <= req.a;
					dvs_q <= req.dvs;
					bsh_q <= {1'b0, req.b};
					sh_q  <= '0;
				end
			end
			MD_MUL: begin
				sh_q  <= mul_nxt;
				bsh_q <= {bsh_q[MUL_W-3:0], 2'b00};
			end
			MD_DIV: sh_q <= {rem_nxt[MAG_W-1:0], sh_q[MAG_W-2:0], q_bit};
			default: ;
		endcase
	end

endmodule

### test/joystick_deadzone_velocity_mapper_tb.sv
// Testbench: joystick events against a local deadzone/rescale predictor, with random stalls.
module joystick_deadzone_velocity_mapper_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import jdvm_pkg::*;

	localparam int FULL_SCALE  = 32767;
	localparam int GAP_PCT     = 21;
	localparam int TAIL_CYCLES = 40;
	localparam int HOLD_CYCLES = 400;

	localparam logic [KIND_W-1:0] KIND_INIT_BIT = 8'h80;
	localparam logic [KIND_W-1:0] KIND_EV_AXIS  = {1'b0, KIND_AXIS};
	localparam logic [KIND_W-1:0] KIND_EV_BTN   = {1'b0, KIND_BUTTON};
	localparam logic [KIND_W-1:0] KIND_NULL     = 8'h00;
	localparam logic [KIND_W-1:0] KIND_MIXED    = 8'h03;
	localparam logic [KIND_W-1:0] KIND_ALL_ONES = 8'hFF;

	localparam logic [IDX_W-1:0] AXIS_Y      = 8'd0;
	localparam logic [IDX_W-1:0] AXIS_X      = 8'd1;
	localparam logic [IDX_W-1:0] AXIS_TURN_A = 8'd2;
	localparam logic [IDX_W-1:0] AXIS_TURN_B = 8'd3;
	localparam logic [IDX_W-1:0] AXIS_EXTRA  = 8'd4;
	localparam logic [IDX_W-1:0] BTN_TOGGLE  = 8'd0;
	localparam logic [IDX_W-1:0] BTN_OTHER   = 8'd1;
	localparam logic signed [LVL_W-1:0] BTN_PRESS   = 16'sd1;
	localparam logic signed [LVL_W-1:0] BTN_RELEASE = 16'sd0;

	localparam logic [REG_IDX_W-1:0] REG_SPARE_FIRST = REG_IDX_W'(REG_MAX_TURN + 1);

	typedef struct packed {
		logic signed [VEL_W-1:0] vel_x;
		logic signed [VEL_W-1:0] vel_y;
		logic signed [VEL_W-1:0] vel_turn;
		logic                    enabled;
	} vel_report_t;

	logic clk;
	logic arst_n;

	jdvm_evt_if evt();
	jdvm_res_if res();
	jdvm_cfg_if cfg();

	joystick_deadzone_velocity_mapper uut (
		.clk(clk),
		.arst_n(arst_n),
		.evt(evt),
		.res(res),
		.cfg(cfg)
	);

	logic [CFG_W-1:0] dz_move_m, dz_turn_m, max_x_m, max_y_m, max_turn_m;
	logic signed [VEL_W-1:0] hold_x_m, hold_y_m, hold_turn_m;
	logic active_m;

	vel_report_t pending_reports[$];
	int errors;
	bit no_gaps;
	int hold_left;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic logic signed [VEL_W-1:0] rescale_axis(input logic signed [LVL_W-1:0] lvl,
		input logic [CFG_W-1:0] dz, input logic [CFG_W-1:0] full);
		logic        neg;
		logic [16:0] mag;
		logic [16:0] m;
		logic [63:0] q;
		neg = lvl[LVL_W-1];
		mag = neg ? (17'h10000 - {1'b0, lvl}) : {1'b0, lvl};
		if (mag < dz)
			return '0;
		m = (mag > FULL_SCALE) ? 17'(FULL_SCALE) : mag;
		if (m <= dz)
			return '0;
		q = (64'(m - dz) * 64'(full)) / 64'(FULL_SCALE - dz);
		return neg ? -$signed(q[VEL_W-1:0]) : $signed(q[VEL_W-1:0]);
	endfunction

	function automatic vel_report_t apply_event(input logic [KIND_W-1:0] kind,
		input logic [IDX_W-1:0] idx, input logic signed [LVL_W-1:0] lvl);
		vel_report_t r;
		if (kind[KIND_W-2:0] == KIND_AXIS) begin
			if (idx == AXIS_Y)
				hold_y_m = rescale_axis(lvl, dz_move_m, max_y_m);
			else if (idx == AXIS_X)
				hold_x_m = rescale_axis(lvl, dz_move_m, max_x_m);
			else if (idx == AXIS_TURN_A || idx == AXIS_TURN_B)
				hold_turn_m = rescale_axis(lvl, dz_turn_m, max_turn_m);
		end else if (kind[KIND_W-2:0] == KIND_BUTTON) begin
			if (idx == BTN_TOGGLE && lvl == BTN_PRESS)
				active_m = ~active_m;
		end
		r.vel_x = hold_x_m;
		r.vel_y = hold_y_m;
		r.vel_turn = hold_turn_m;
		r.enabled = active_m;
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		vel_report_t want;
		if (arst_n && res.valid && res.ready) begin
			if (pending_reports.size() == 0) begin
				errors++;
				$error("result transaction with nothing pending");
			end else begin
				want = pending_reports.pop_front();
				if (res.vel_x !== want.vel_x) begin
					errors++;
					$error("vel_x: expected %0d, actual %0d", want.vel_x, res.vel_x);
				end
				if (res.vel_y !== want.vel_y) begin
					errors++;
					$error("vel_y: expected %0d, actual %0d", want.vel_y, res.vel_y);
				end
				if (res.vel_turn !== want.vel_turn) begin
					errors++;
					$error("vel_turn: expected %0d, actual %0d", want.vel_turn, res.vel_turn);
				end
				if (res.enabled !== want.enabled) begin
					errors++;
					$error("enabled: expected %0d, actual %0d", want.enabled, res.enabled);
				end
			end
		end
	end

	// result ready: random gaps, gap-free stretches, long hold-off
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			res.ready <= 1'b0;
		end else if (no_gaps) begin
			res.ready <= 1'b1;
		end else begin
			res.ready <= ($urandom_range(99) >= GAP_PCT);
		end
	end

	task automatic send_event(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
		input logic signed [LVL_W-1:0] lvl);
		if (!no_gaps && $urandom_range(99) < GAP_PCT) begin
			evt.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		evt.valid <= 1'b1;
		evt.event_kind <= kind;
		evt.event_index <= idx;
		evt.event_level <= lvl;
		do @(posedge clk); while (!evt.ready);
		pending_reports.push_back(apply_event(kind, idx, lvl));
	endtask

	task automatic drain();
		evt.valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg.valid <= 1'b1;
		cfg.reg_index <= idx;
		cfg.wdata <= val;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			REG_DZ_MOVE:  dz_move_m = val;
			REG_DZ_TURN:  dz_turn_m = val;
			REG_MAX_X:    max_x_m = val;
			REG_MAX_Y:    max_y_m = val;
			REG_MAX_TURN: max_turn_m = val;
			default: ;
		endcase
	endtask

	task automatic write_settings(input logic [CFG_W-1:0] dzm, input logic [CFG_W-1:0] dzt,
		input logic [CFG_W-1:0] mx, input logic [CFG_W-1:0] my, input logic [CFG_W-1:0] mt,
		input bit with_spare);
		write_reg(REG_DZ_MOVE, dzm);
		write_reg(REG_DZ_TURN, dzt);
		write_reg(REG_MAX_X, mx);
		write_reg(REG_MAX_Y, my);
		write_reg(REG_MAX_TURN, mt);
		if (with_spare)
			for (int i = REG_SPARE_FIRST; i < (1 << REG_IDX_W); i++)
				write_reg(REG_IDX_W'(i), CFG_W'($urandom));
		cfg.valid <= 1'b0;
	endtask

	function automatic logic signed [LVL_W-1:0] pick_level(input logic [CFG_W-1:0] dz);
		int v;
		case ($urandom_range(9))
			0: return 16'sd32767;
			1: return -16'sd32768;
			2: return -16'sd32767;
			3: return 16'sd0;
			4, 5: begin
				v = int'(dz) + int'($urandom_range(8)) - 4;
				if (v > FULL_SCALE)
					v = FULL_SCALE;
				if ($urandom_range(1))
					v = -v;
				return LVL_W'(v);
			end
			default: return LVL_W'($urandom);
		endcase
	endfunction

	task automatic send_random_event();
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0] idx;
		logic signed [LVL_W-1:0] lvl;
		int sel;
		sel = $urandom_range(99);
		if (sel < 60) begin
			kind = $urandom_range(1) ? (KIND_INIT_BIT | KIND_EV_AXIS) : KIND_EV_AXIS;
			idx = ($urandom_range(9) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(3));
			lvl = pick_level((idx == AXIS_TURN_A || idx == AXIS_TURN_B) ? dz_turn_m : dz_move_m);
		end else if (sel < 80) begin
			kind = $urandom_range(1) ? (KIND_INIT_BIT | KIND_EV_BTN) : KIND_EV_BTN;
			idx = ($urandom_range(3) == 0) ? IDX_W'($urandom) : BTN_TOGGLE;
			case ($urandom_range(4))
				0, 1: lvl = BTN_PRESS;
				2, 3: lvl = BTN_RELEASE;
				default: lvl = LVL_W'($urandom);
			endcase
		end else begin
			kind = KIND_W'($urandom);
			idx = IDX_W'($urandom);
			lvl = LVL_W'($urandom);
		end
		send_event(kind, idx, lvl);
	endtask

	task automatic test_directed_defaults();
		send_event(KIND_EV_AXIS, AXIS_Y, 16'sd32767);
		send_event(KIND_EV_AXIS, AXIS_Y, -16'sd32768);
		send_event(KIND_EV_AXIS, AXIS_X, -16'sd32767);
		send_event(KIND_EV_AXIS, AXIS_X, 16'sd32767);
		send_event(KIND_EV_AXIS, AXIS_Y, 16'sd3999);
		send_event(KIND_EV_AXIS, AXIS_Y, 16'sd4000);
		send_event(KIND_EV_AXIS, AXIS_Y, 16'sd4001);
		send_event(KIND_EV_AXIS, AXIS_X, -16'sd4001);
		send_event(KIND_EV_AXIS, AXIS_TURN_A, 16'sd8000);
		send_event(KIND_EV_AXIS, AXIS_TURN_B, -16'sd20000);
		send_event(KIND_EV_AXIS, AXIS_TURN_A, 16'sd0);
		send_event(KIND_EV_AXIS, AXIS_EXTRA, 16'sd1000);
		send_event(KIND_EV_AXIS, 8'hFF, -16'sd1000);
		send_event(KIND_EV_BTN, BTN_TOGGLE, BTN_PRESS);
		send_event(KIND_EV_BTN, BTN_TOGGLE, BTN_RELEASE);
		send_event(KIND_EV_BTN, BTN_TOGGLE, 16'sd2);
		send_event(KIND_EV_BTN, BTN_TOGGLE, -16'sd1);
		send_event(KIND_EV_BTN, BTN_OTHER, BTN_PRESS);
		send_event(KIND_INIT_BIT | KIND_EV_BTN, BTN_TOGGLE, BTN_PRESS);
		send_event(KIND_INIT_BIT | KIND_EV_AXIS, AXIS_X, 16'sd12345);
		send_event(KIND_NULL, BTN_TOGGLE, BTN_PRESS);
		send_event(KIND_MIXED, AXIS_Y, 16'sd20000);
		send_event(KIND_ALL_ONES, BTN_TOGGLE, BTN_PRESS);
		send_event(KIND_INIT_BIT, AXIS_X, -16'sd32768);
		drain();
	endtask

	task automatic test_setting_sweep();
		logic [CFG_W-1:0] sweep[7][5];
		sweep[0] = '{15'd0, 15'd0, 15'd32767, 15'd32767, 15'd32767};
		sweep[1] = '{15'd32767, 15'd32767, 15'd1, 15'd1, 15'd1};
		sweep[2] = '{15'd32766, 15'd32766, 15'd32767, 15'd32767, 15'd32767};
		sweep[3] = '{15'd0, 15'd32766, 15'd0, 15'd0, 15'd0};
		sweep[4] = '{15'd1, 15'd16384, 15'd12345, 15'd255, 15'd32767};
		for (int s = 5; s < 7; s++)
			for (int r = 0; r < 5; r++)
				sweep[s][r] = CFG_W'($urandom);
		for (int s = 0; s < 7; s++) begin
			write_settings(sweep[s][0], sweep[s][1], sweep[s][2], sweep[s][3], sweep[s][4],
				s == 0);
			send_event(KIND_EV_AXIS, AXIS_X, -16'sd32768);
			send_event(KIND_EV_AXIS, AXIS_Y, 16'sd32767);
			send_event(KIND_EV_AXIS, AXIS_TURN_B, -16'sd32767);
			repeat (50) send_random_event();
			drain();
		end
	endtask

	task automatic test_random_traffic();
		write_settings(DZ_MOVE_RST, DZ_TURN_RST, MAX_X_RST, MAX_Y_RST, MAX_TURN_RST, 1'b0);
		no_gaps = 1'b1;
		repeat (150) send_random_event();
		no_gaps = 1'b0;
		repeat (100) send_random_event();
		drain();
		write_settings(CFG_W'($urandom_range(6000)), CFG_W'($urandom_range(12000)),
			CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), 1'b1);
		repeat (150) send_random_event();
		drain();
	endtask

	task automatic test_backpressure();
		hold_left = HOLD_CYCLES;
		no_gaps = 1'b1;
		repeat (40) send_random_event();
		no_gaps = 1'b0;
		drain();
		repeat (60) send_random_event();
		drain();
	endtask

	initial begin
		errors = 0;
		no_gaps = 1'b0;
		hold_left = 0;
		arst_n <= 1'b0;
		evt.valid <= 1'b0;
		evt.event_kind <= '0;
		evt.event_index <= '0;
		evt.event_level <= '0;
		cfg.valid <= 1'b0;
		cfg.reg_index <= '0;
		cfg.wdata <= '0;
		dz_move_m = DZ_MOVE_RST;
		dz_turn_m = DZ_TURN_RST;
		max_x_m = MAX_X_RST;
		max_y_m = MAX_Y_RST;
		max_turn_m = MAX_TURN_RST;
		hold_x_m = '0;
		hold_y_m = '0;
		hold_turn_m = '0;
		active_m = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed_defaults();
		test_setting_sweep();
		test_random_traffic();
		test_backpressure();

		if (errors == 0 && pending_reports.size() == 0)
			$display("joystick_deadzone_velocity_mapper: match");
		else
			$display("joystick_deadzone_velocity_mapper: mismatch");
		$finish;
	end

	initial begin
		#5ms;
		$display("joystick_deadzone_velocity_mapper: mismatch");
		$finish;
	end

endmodule

### sim.f
hdl/jdvm_pkg.sv
hdl/jdvm_evt_if.sv
hdl/jdvm_res_if.sv
hdl/jdvm_cfg_if.sv
hdl/jdvm_muldiv.sv
hdl/joystick_deadzone_velocity_mapper.sv
test/joystick_deadzone_velocity_mapper_tb.sv
